### design/itaf_pkg.sv
// Package for the integer-to-ASCII formatter: request/result structs, state
// and conversion-code enums, ASCII constants and the digit-to-character map.
// No dependencies.
package itaf_pkg;

    typedef enum logic [1:0] {
        REQ_SDEC = 2'd0,
        REQ_UDEC = 2'd1,
        REQ_HEX  = 2'd2,
        REQ_PTR  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PFX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] value;
        t_req_type   req_type;
    } t_req;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_res;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LOW_X = 8'h78;

    localparam int unsigned NUM_DEC_DIGITS = 10;
    localparam int unsigned NUM_HEX_DIGITS = 8;
    localparam int unsigned PTR_MIN_DIGITS = 8;

    // Map one digit (0..15) to its lowercase ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {4'd0, d};
        end else begin
            ch = CH_LOW_A + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

### design/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter top level: bit-serial binary-to-BCD conversion
// and a nibble-serial character emitter. Depends on itaf_pkg.
//
// Usage: raise start with a request on i_req while busy is low; the request is
// taken at that edge. Characters then appear one per strobe on o_res, most
// significant first, with last_char set on the final one; the receiver cannot
// stall and must take each character in the cycle it is shown. A request keeps
// the block busy for a span set by the shift-add-3 loop for decimal and by
// the digit shift register for all codes: decimal runs 32 conversion steps,
// one input bit each, then 10 digit slots; hex runs one nibble slot for each of
// its 8 digits; pointer runs the "x" slot plus 8 nibble slots. The first
// character ('-' or '0' of "0x") leaves with the accept edge. Suppressed
// leading zeros take a slot but no strobe. A new request may be given in the
// cycle that shows the last character.
module integer_to_ascii_formatter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  itaf_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output itaf_pkg::t_res o_res
);

    // Control state
    itaf_pkg::t_state r_state, n_state;
    logic [4:0]       r_bitcnt, n_bitcnt;  // conversion steps left minus one
    logic [3:0]       r_cnt, n_cnt;        // digit slots left
    logic [3:0]       r_min, n_min;        // slots that always print
    logic             r_started, n_started;
    logic             r_strobe, n_strobe;

    // Datapath
    logic [31:0]      r_bin, n_bin;        // binary shift register, MSB out
    logic [39:0]      r_dig, n_dig;        // digit shift register, top digit out
    itaf_pkg::t_res   r_res, n_res;

    logic [3:0]       w_top;
    logic [39:0]      w_adj;
    logic [31:0]      w_mag;

    assign w_top = r_dig[39:36];
    assign w_mag = 32'd0 - i_req.value;

    always_comb begin
        // Add 3 to every BCD digit of 5 or more before the next shift.
        for (int k = 0; k < 10; k++) begin
            if (r_dig[4*k +: 4] >= 4'd5) begin
                w_adj[4*k +: 4] = r_dig[4*k +: 4] + 4'd3;
            end else begin
                w_adj[4*k +: 4] = r_dig[4*k +: 4];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_bitcnt  = r_bitcnt;
        n_cnt     = r_cnt;
        n_min     = r_min;
        n_started = r_started;
        n_bin     = r_bin;
        n_dig     = r_dig;
        n_strobe  = 1'b0;
        n_res     = r_res;

        unique case (r_state)
            itaf_pkg::ST_IDLE: begin
                if (start) begin
                    n_started = 1'b0;
                    n_bitcnt  = 5'd31;
                    n_dig     = '0;
                    n_min     = 4'd1;
                    unique case (i_req.req_type)
                        itaf_pkg::REQ_SDEC: begin
                            n_state = itaf_pkg::ST_CONV;
                            if (i_req.value[31]) begin
                                // Emit the sign now, convert the magnitude.
                                n_bin    = w_mag;
                                n_strobe = 1'b1;
                                n_res    = '{char_code: itaf_pkg::CH_MINUS, last_char: 1'b0};
                            end else begin
                                n_bin = i_req.value;
                            end
                        end
                        itaf_pkg::REQ_UDEC: begin
                            n_state = itaf_pkg::ST_CONV;
                            n_bin   = i_req.value;
                        end
                        itaf_pkg::REQ_HEX: begin
                            n_state = itaf_pkg::ST_EMIT;
                            n_dig   = {i_req.value, 8'h00};
                            n_cnt   = 4'(itaf_pkg::NUM_HEX_DIGITS);
                        end
                        itaf_pkg::REQ_PTR: begin
                            // Emit the '0' of the prefix, 'x' follows.
                            n_state  = itaf_pkg::ST_PFX;
                            n_dig    = {i_req.value, 8'h00};
                            n_cnt    = 4'(itaf_pkg::NUM_HEX_DIGITS);
                            n_min    = 4'(itaf_pkg::PTR_MIN_DIGITS);
                            n_strobe = 1'b1;
                            n_res    = '{char_code: itaf_pkg::CH_ZERO, last_char: 1'b0};
                        end
                        default: n_state = itaf_pkg::ST_IDLE;
                    endcase
                end
            end

            itaf_pkg::ST_CONV: begin
                // One shift-add-3 step per cycle, binary MSB into BCD LSB.
                n_dig    = {w_adj[38:0], r_bin[31]};
                n_bin    = {r_bin[30:0], 1'b0};
                n_bitcnt = r_bitcnt - 5'd1;
                if (r_bitcnt == 5'd0) begin
                    n_state = itaf_pkg::ST_EMIT;
                    n_cnt   = 4'(itaf_pkg::NUM_DEC_DIGITS);
                end
            end

            itaf_pkg::ST_PFX: begin
                n_state  = itaf_pkg::ST_EMIT;
                n_strobe = 1'b1;
                n_res    = '{char_code: itaf_pkg::CH_LOW_X, last_char: 1'b0};
            end

            itaf_pkg::ST_EMIT: begin
                // Drop leading zeros until a nonzero digit or the padding width.
                n_dig = {r_dig[35:0], 4'h0};
                n_cnt = r_cnt - 4'd1;
                if (r_started || (w_top != 4'h0) || (r_cnt <= r_min)) begin
                    n_started = 1'b1;
                    n_strobe  = 1'b1;
                    n_res     = '{char_code: itaf_pkg::digit_char(w_top),
                                  last_char: (r_cnt == 4'd1)};
                end
                if (r_cnt == 4'd1) begin
                    n_state = itaf_pkg::ST_IDLE;
                end
            end

            default: n_state = itaf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= itaf_pkg::ST_IDLE;
            r_strobe  <= 1'b0;
            r_started <= 1'b0;
            r_bitcnt  <= '0;
            r_cnt     <= '0;
            r_min     <= 4'd1;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_started <= n_started;
            r_bitcnt  <= n_bitcnt;
            r_cnt     <= n_cnt;
            r_min     <= n_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_dig <= n_dig;
        r_res <= n_res;
    end

    assign busy     = (r_state != itaf_pkg::ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

### design/itaf_checker.sv
// Port-level checker for the integer-to-ASCII formatter, with its bind.
// Depends on itaf_pkg and the integer_to_ascii_formatter ports.
module itaf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input itaf_pkg::t_res o_res
);

    // Every accepted request raises busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // The final character shows as the block frees up.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.last_char) |-> !busy)
        else $error("last character while still busy");

    // More characters follow a non-final one, so the block stays busy.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last_char) |-> busy)
        else $error("non-final character while idle");

    // Only digits, lowercase hex letters, '-' and 'x' are ever emitted.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_res.char_code >= itaf_pkg::CH_ZERO &&
                       o_res.char_code <= itaf_pkg::CH_NINE) ||
                      (o_res.char_code >= itaf_pkg::CH_LOW_A &&
                       o_res.char_code <= itaf_pkg::CH_LOW_F) ||
                      o_res.char_code == itaf_pkg::CH_MINUS ||
                      o_res.char_code == itaf_pkg::CH_LOW_X))
        else $error("character outside the output set");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

### test/itaf_checker.sv
// Scoreboard for the integer-to-ASCII formatter: predicts the character stream
// of every accepted request and compares each strobed character against it.
// Depends on itaf_pkg for the request/result structs and ASCII constants.
module itaf_scoreboard (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  itaf_pkg::t_req  i_req,
    input  logic            i_strobe,
    input  itaf_pkg::t_res  i_res,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    itaf_pkg::t_res pending_chars[$];
    int             fail_count = 0;

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Queue the characters one request should produce, most significant first.
    function automatic void format_value(input itaf_pkg::t_req req);
        logic [31:0]    mag;
        logic [31:0]    radix;
        logic [3:0]     digits [10];
        logic [7:0]     text [$];
        itaf_pkg::t_res entry;
        int             nd;
        int             pad_width;
        mag       = req.value;
        radix     = 32'd10;
        nd        = 0;
        pad_width = 1;
        case (req.req_type)
            itaf_pkg::REQ_SDEC: begin
                if (mag[31]) begin
                    text.push_back(itaf_pkg::CH_MINUS);
                    mag = -mag;
                end
            end
            itaf_pkg::REQ_HEX: begin
                radix = 32'd16;
            end
            itaf_pkg::REQ_PTR: begin
                radix     = 32'd16;
                pad_width = int'(itaf_pkg::PTR_MIN_DIGITS);
                text.push_back(itaf_pkg::CH_ZERO);
                text.push_back(itaf_pkg::CH_LOW_X);
            end
            default: ;
        endcase
        do begin
            digits[nd] = 4'(mag % radix);
            nd++;
            mag = mag / radix;
        end while (mag != 32'd0 && nd < 10);
        while (nd < pad_width) begin
            digits[nd] = 4'd0;
            nd++;
        end
        while (nd > 0) begin
            nd--;
            if (digits[nd] < 4'd10) begin
                text.push_back(itaf_pkg::CH_ZERO + 8'(digits[nd]));
            end else begin
                text.push_back(itaf_pkg::CH_LOW_A + 8'(digits[nd]) - 8'd10);
            end
        end
        foreach (text[i]) begin
            entry.char_code = text[i];
            entry.last_char = (i == text.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        itaf_pkg::t_res want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                format_value(i_req);
            end
            if (i_strobe) begin
                if (pending_chars.size() == 0) begin
                    note_failure($sformatf("unexpected char 0x%02h last=%0b",
                                           i_res.char_code, i_res.last_char));
                end else begin
                    want = pending_chars.pop_front();
                    if (i_res.char_code !== want.char_code ||
                        i_res.last_char !== want.last_char) begin
                        note_failure($sformatf(
                            "char exp 0x%02h act 0x%02h, last exp %0b act %0b",
                            want.char_code, i_res.char_code,
                            want.last_char, i_res.last_char));
                    end
                end
            end
        end
        o_pending    <= pending_chars.size();
        o_fail_count <= fail_count;
    end

endmodule

### test/tb_top.sv
// Top-level testbench for integer_to_ascii_formatter: clock, reset, request
// stimulus, watchdog and verdict. Depends on itaf_pkg, the formatter RTL and
// itaf_scoreboard, which does all prediction and comparison.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Even a decimal request, the longest kind, stays busy far less than this, so a
    // quiet spell of this length can only mean a hang.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to linger after the last character for stray strobes.
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_REQS    = 350;
    // Hold the sender until the scoreboard is empty every this many requests.
    localparam int DRAIN_EVERY    = 60;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic           o_strobe;
    itaf_pkg::t_req i_req;
    itaf_pkg::t_res o_res;

    int fail_count;
    int chars_pending;
    int idle_cycles;
    int burst_left;
    int kind_count [4];

    integer_to_ascii_formatter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    itaf_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (chars_pending)
    );

    // 8 ns clock, low first so the first falling edge sits at time zero.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Present one request from a falling edge and hold it until the block
    // takes it. Returns on the falling edge after the accept, so the next
    // call can keep start high for back-to-back requests without a glitch.
    task automatic issue_request(input logic [31:0] value,
                                 input itaf_pkg::t_req_type kind);
        int gap;
        gap = (burst_left > 0) ? 0 : $urandom_range(0, 3);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{value: value, req_type: kind};
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        kind_count[kind]++;
        @(negedge i_clk);
    endtask

    // Drop start and wait for every predicted character to arrive.
    task automatic drain_pending();
        start <= 1'b0;
        @(negedge i_clk);
        while (chars_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Abort if nothing moves across the interface for too long.
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [31:0]         operand;
        itaf_pkg::t_req_type kind;
        start      = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        burst_left = 0;
        foreach (kind_count[k]) begin
            kind_count[k] = 0;
        end

        // Synchronous reset, released on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero for every code, sign handling around the most
        // negative value, digit-count boundaries, and pointer zero padding.
        issue_request(32'h0000_0000, itaf_pkg::REQ_SDEC);
        issue_request(32'h0000_0001, itaf_pkg::REQ_SDEC);
        issue_request(32'h7fff_ffff, itaf_pkg::REQ_SDEC);
        issue_request(32'h8000_0000, itaf_pkg::REQ_SDEC);
        issue_request(32'h8000_0001, itaf_pkg::REQ_SDEC);
        issue_request(32'hffff_ffff, itaf_pkg::REQ_SDEC);
        issue_request(32'h0000_0000, itaf_pkg::REQ_UDEC);
        issue_request(32'd9,         itaf_pkg::REQ_UDEC);
        issue_request(32'd10,        itaf_pkg::REQ_UDEC);
        issue_request(32'd1000000000, itaf_pkg::REQ_UDEC);
        issue_request(32'hffff_ffff, itaf_pkg::REQ_UDEC);
        issue_request(32'h0000_0000, itaf_pkg::REQ_HEX);
        issue_request(32'h0000_000f, itaf_pkg::REQ_HEX);
        issue_request(32'h0000_0010, itaf_pkg::REQ_HEX);
        issue_request(32'hdead_beef, itaf_pkg::REQ_HEX);
        issue_request(32'hffff_ffff, itaf_pkg::REQ_HEX);
        issue_request(32'h0000_0000, itaf_pkg::REQ_PTR);
        issue_request(32'h0000_000a, itaf_pkg::REQ_PTR);
        issue_request(32'h1234_5678, itaf_pkg::REQ_PTR);
        issue_request(32'hffff_ffff, itaf_pkg::REQ_PTR);
        drain_pending();

        // Random: mixed operand shapes so short and long strings both occur,
        // with occasional zero-gap bursts and periodic full drains.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
                burst_left = $urandom_range(8, 20);
            end
            case ($urandom_range(0, 5))
                0: operand = $urandom;
                1: operand = $urandom_range(0, 20);
                2: operand = $urandom >> $urandom_range(0, 31);
                3: begin
                    // Near the signed and unsigned extremes.
                    case ($urandom_range(0, 2))
                        0: operand = 32'h8000_0000 + $urandom_range(0, 3);
                        1: operand = 32'h7fff_ffff - $urandom_range(0, 3);
                        default: operand = 32'hffff_ffff - $urandom_range(0, 3);
                    endcase
                end
                4: begin
                    // Just below or at a power of ten or sixteen.
                    operand = 32'd1;
                    if ($urandom_range(0, 1) == 0) begin
                        repeat ($urandom_range(0, 9)) operand = operand * 32'd10;
                    end else begin
                        operand = operand << (4 * $urandom_range(0, 7));
                    end
                    operand = operand - $urandom_range(0, 1);
                end
                default: operand = -$urandom_range(1, 20);
            endcase
            kind = itaf_pkg::t_req_type'($urandom_range(0, 3));
            issue_request(operand, kind);
            if ((n + 1) % DRAIN_EVERY == 0) begin
                drain_pending();
            end
        end

        drain_pending();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: signed %0d, unsigned %0d, hex %0d, pointer %0d",
                 kind_count[itaf_pkg::REQ_SDEC] + kind_count[itaf_pkg::REQ_UDEC] +
                 kind_count[itaf_pkg::REQ_HEX] + kind_count[itaf_pkg::REQ_PTR],
                 kind_count[itaf_pkg::REQ_SDEC], kind_count[itaf_pkg::REQ_UDEC],
                 kind_count[itaf_pkg::REQ_HEX], kind_count[itaf_pkg::REQ_PTR]);
        $display("Edge operands plus randomized values and gaps; %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
design/itaf_pkg.sv
design/integer_to_ascii_formatter.sv
design/itaf_checker.sv
test/itaf_checker.sv
test/tb_top.sv
